>>> hw/rtl/hfsrgb_pkg.sv
// Shared types, constants and threshold table for the half-float to sRGB8 texel unit.
`default_nettype none

package hfsrgb_pkg;

  localparam int CODE_W      = 8;
  localparam int SRCH_STAGES = CODE_W;
  localparam int CHAN_W      = 16;
  localparam int MAG_W       = 15;
  localparam int UNITS_W     = 24;
  localparam int BIG_W       = 320;
  localparam int THR_DEPTH   = 2 ** CODE_W;

  localparam logic [CHAN_W-1:0] HALF_ONE = 16'h3C00;

  typedef enum logic [1:0] {
    MODE_RGBA8 = 2'd0,
    MODE_BGRA8 = 2'd1,
    MODE_HALF  = 2'd2
  } mode_t;

  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic [CHAN_W-1:0] chan3;
    logic              last_in;
  } texel_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
    logic [CODE_W-1:0] alpha;
    logic              clipped_so_far;
    logic              last_out;
  } result_t;

  typedef struct packed {
    logic              pass;
    logic [CODE_W-1:0] pass_byte;
    logic [CHAN_W-1:0] half;
  } lane_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] red;
    logic [CODE_W-1:0] green;
    logic [CODE_W-1:0] blue;
    logic [CODE_W-1:0] alpha;
    logic [2:0]        clip;
    logic              last;
  } merge_in_t;

  typedef logic [MAG_W-1:0] thr_table_t [THR_DEPTH];

  // Magnitude of a positive half below one, in units of 2^-24.
  function automatic logic [UNITS_W-1:0] half_units(input logic [MAG_W-1:0] h);
    logic [4:0]         e;
    logic [9:0]         f;
    logic [UNITS_W-1:0] m;
    e = h[14:10];
    f = h[9:0];
    if (e == 5'd0) begin
      m = UNITS_W'(f);
    end else begin
      m = UNITS_W'({1'b1, f}) << (e - 5'd1);
    end
    return m;
  endfunction

  // True when linear value m * 2^-24 encodes to a code of at least k.
  function automatic logic srgb_code_ge(input logic [UNITS_W-1:0] m,
                                        input logic [CODE_W-1:0] k);
    logic [BIG_W-1:0] lhs;
    logic [BIG_W-1:0] rhs;
    logic [BIG_W-1:0] base;
    logic [63:0]      lin;
    logic             ge;
    lin = 64'(m) * 64'd10000000;
    if (lin <= (64'd31308 << 24)) begin
      ge = (64'(m) * 64'd32946 + (64'd5 << 24)) >= ((64'(k) * 64'd10) << 24);
    end else begin
      lhs  = BIG_W'(1);
      rhs  = BIG_W'(1);
      base = BIG_W'(k) * BIG_W'(40) + BIG_W'(541);
      for (int i = 0; i < 5; i++) begin
        lhs = lhs * BIG_W'(m);
        rhs = rhs << 24;
      end
      for (int i = 0; i < 12; i++) begin
        lhs = lhs * BIG_W'(10761);
        rhs = rhs * base;
      end
      ge = (lhs >= rhs);
    end
    return ge;
  endfunction

  // Smallest half bit pattern below one that reaches code k; one if none does.
  function automatic logic [MAG_W-1:0] srgb_threshold(input logic [CODE_W-1:0] k);
    logic [MAG_W-1:0] lo;
    logic [MAG_W-1:0] hi;
    logic [MAG_W-1:0] mid;
    lo = MAG_W'(1);
    hi = HALF_ONE[MAG_W-1:0];
    for (int i = 0; i < MAG_W; i++) begin
      if (lo < hi) begin
        mid = MAG_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
        if (srgb_code_ge(half_units(mid), k)) begin
          hi = mid;
        end else begin
          lo = mid + MAG_W'(1);
        end
      end
    end
    return lo;
  endfunction

  function automatic thr_table_t build_srgb_table();
    thr_table_t t;
    t[0] = '0;
    for (int k = 1; k < THR_DEPTH; k++) begin
      t[k] = srgb_threshold(CODE_W'(k));
    end
    return t;
  endfunction

  localparam thr_table_t SRGB_THR = build_srgb_table();

endpackage

`default_nettype wire

>>> hw/rtl/hfsrgb_colour_lane.sv
// Colour lane: half decode and pipelined binary search over the sRGB code thresholds.
`default_nettype none

module hfsrgb_colour_lane (
  input  wire logic                                   clk,
  input  wire logic [hfsrgb_pkg::SRCH_STAGES-1:0]     en,
  input  wire hfsrgb_pkg::lane_in_t                   lane,
  output logic      [hfsrgb_pkg::CODE_W-1:0]          code,
  output logic                                        clip
);

  typedef struct packed {
    logic                           fix;
    logic                           clip;
    logic [hfsrgb_pkg::MAG_W-1:0]   mag;
    logic [hfsrgb_pkg::CODE_W-1:0]  code;
  } srch_t;

  srch_t dec;
  srch_t st [hfsrgb_pkg::SRCH_STAGES];
  logic  is_nan;

  assign is_nan = (lane.half[14:10] == 5'h1F) && (lane.half[9:0] != 10'd0);

  always_comb begin
    dec.mag  = lane.half[hfsrgb_pkg::MAG_W-1:0];
    dec.code = '0;
    dec.fix  = 1'b1;
    dec.clip = 1'b0;
    if (lane.pass) begin
      dec.code = lane.pass_byte;
    end else if (is_nan || lane.half[15] || (lane.half == '0)) begin
      dec.code = '0;
    end else if (lane.half > hfsrgb_pkg::HALF_ONE) begin
      dec.code = '1;
      dec.clip = 1'b1;
    end else if (lane.half == hfsrgb_pkg::HALF_ONE) begin
      dec.code = '1;
    end else begin
      dec.fix = 1'b0;
    end
  end

  for (genvar j = 0; j < hfsrgb_pkg::SRCH_STAGES; j++) begin : g_stage
    localparam logic [hfsrgb_pkg::CODE_W-1:0] BIT_MASK =
      hfsrgb_pkg::CODE_W'(1) << (hfsrgb_pkg::CODE_W - 1 - j);

    srch_t                          prev;
    srch_t                          nxt;
    logic [hfsrgb_pkg::CODE_W-1:0]  cand;

    if (j == 0) begin : g_first
      assign prev = dec;
    end else begin : g_rest
      assign prev = st[j-1];
    end

    // try the next code bit against its threshold
    always_comb begin
      cand = prev.code | BIT_MASK;
      nxt  = prev;
      if (!prev.fix && (prev.mag >= hfsrgb_pkg::SRGB_THR[cand])) begin
        nxt.code = cand;
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j] <= nxt;
      end
    end
  end

  assign code = st[hfsrgb_pkg::SRCH_STAGES-1].code;
  assign clip = st[hfsrgb_pkg::SRCH_STAGES-1].clip;

endmodule

`default_nettype wire

>>> hw/rtl/hfsrgb_alpha_lane.sv
// Alpha lane: linear scale and round of a half to a byte, delayed to match the colour lanes.
`default_nettype none

module hfsrgb_alpha_lane (
  input  wire logic                                   clk,
  input  wire logic [hfsrgb_pkg::SRCH_STAGES-1:0]     en,
  input  wire hfsrgb_pkg::lane_in_t                   lane,
  output logic      [hfsrgb_pkg::CODE_W-1:0]          alpha
);

  localparam int PROD_W = hfsrgb_pkg::UNITS_W + hfsrgb_pkg::CODE_W + 1;

  logic [hfsrgb_pkg::CODE_W-1:0] a_calc;
  logic [hfsrgb_pkg::CODE_W-1:0] a_pipe [hfsrgb_pkg::SRCH_STAGES];
  logic [PROD_W-1:0]             prod;
  logic                          is_nan;

  assign is_nan = (lane.half[14:10] == 5'h1F) && (lane.half[9:0] != 10'd0);

  assign prod = PROD_W'(hfsrgb_pkg::half_units(lane.half[hfsrgb_pkg::MAG_W-1:0]))
              * PROD_W'(255)
              + (PROD_W'(1) << (hfsrgb_pkg::UNITS_W - 1));

  always_comb begin
    if (lane.pass) begin
      a_calc = lane.pass_byte;
    end else if (is_nan || lane.half[15]) begin
      a_calc = '0;
    end else if (lane.half >= hfsrgb_pkg::HALF_ONE) begin
      a_calc = '1;
    end else begin
      a_calc = prod[hfsrgb_pkg::UNITS_W +: hfsrgb_pkg::CODE_W];
    end
  end

  for (genvar j = 0; j < hfsrgb_pkg::SRCH_STAGES; j++) begin : g_delay
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (en[j]) begin
          a_pipe[j] <= a_calc;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (en[j]) begin
          a_pipe[j] <= a_pipe[j-1];
        end
      end
    end
  end

  assign alpha = a_pipe[hfsrgb_pkg::SRCH_STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/hfsrgb_merge.sv
// Merge stage: joins the lane results, keeps the sticky clip flag and holds the output register.
`default_nettype none

module hfsrgb_merge (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire hfsrgb_pkg::merge_in_t  mi,
  input  wire logic                   mi_valid,
  output logic                        take,
  output logic                        result_valid,
  input  wire logic                   result_ready,
  output hfsrgb_pkg::result_t         result
);

  logic sticky;
  logic sticky_next;
  logic flag;

  assign take        = !result_valid || result_ready;
  assign flag        = sticky || (mi.clip != 3'd0);
  assign sticky_next = mi.last ? 1'b0 : flag;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      sticky       <= 1'b0;
    end else if (take) begin
      result_valid <= mi_valid;
      if (mi_valid) begin
        sticky <= sticky_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.red            <= mi.red;
      result.green          <= mi.green;
      result.blue           <= mi.blue;
      result.alpha          <= mi.alpha;
      result.clipped_so_far <= flag;
      result.last_out       <= mi.last;
    end
  end

  a_last_clears_sticky: assert property (@(posedge clk) disable iff (rst)
    (take && mi_valid && mi.last) |=> !sticky)
    else $error("sticky clip survived the final texel");

  a_sticky_reported: assert property (@(posedge clk) disable iff (rst)
    (take && mi_valid && sticky) |=> (result_valid && result.clipped_so_far))
    else $error("set sticky flag not reported on result");

  a_sticky_holds_idle: assert property (@(posedge clk) disable iff (rst)
    !(take && mi_valid) |=> (sticky == $past(sticky)))
    else $error("sticky flag moved without a transaction");

  a_clip_reported: assert property (@(posedge clk) disable iff (rst)
    (take && mi_valid && (mi.clip != 3'd0)) |=> result.clipped_so_far)
    else $error("lane clip lost at merge");

endmodule

`default_nettype wire

>>> hw/rtl/half_float_to_srgb8_texel_unit.sv
// Top level of the half-float to sRGB8 texel unit.
//
// Input channel texel_valid/texel_ready carries one texel per transaction:
// four 16-bit channels and a last flag. Output channel result_valid/
// result_ready carries one RGBA8 texel per transaction with the running
// clip flag and a copy of the last flag. cfg_wen/cfg_wdata write the
// format mode (RGBA8 pass, BGRA8 swap, half float); write it only while
// the unit is empty.
// The accepting edge loads the first of eight stages of binary search over
// the 256-entry sRGB threshold table, one code bit per stage, followed by
// the merge/output register. Throughput is one texel per clock while the
// receiver does not stall the output.
// Reset empties the pipeline, clears the sticky clip flag and selects the
// RGBA8 mode. When the receiver stalls, the output register holds its
// result and the stages behind it keep filling; texel_ready drops only
// once every stage holds a texel.
`default_nettype none

module half_float_to_srgb8_texel_unit (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wen,
  input  wire logic [1:0]            cfg_wdata,
  input  wire logic                  texel_valid,
  output logic                       texel_ready,
  input  wire hfsrgb_pkg::texel_t    texel,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output hfsrgb_pkg::result_t        result
);

  localparam int NSTG = hfsrgb_pkg::SRCH_STAGES;

  logic [1:0]               format_mode;
  logic [NSTG:0]            en;
  logic [NSTG-1:0]          vld;
  logic [NSTG-1:0]          last_pipe;
  hfsrgb_pkg::lane_in_t     lane_r;
  hfsrgb_pkg::lane_in_t     lane_g;
  hfsrgb_pkg::lane_in_t     lane_b;
  hfsrgb_pkg::lane_in_t     lane_a;
  hfsrgb_pkg::merge_in_t    mi;
  logic [2:0]               clip;
  logic                     take;

  always_ff @(posedge clk) begin
    if (rst) begin
      format_mode <= hfsrgb_pkg::MODE_RGBA8;
    end else if (cfg_wen) begin
      format_mode <= cfg_wdata;
    end
  end

  always_comb begin
    lane_r = '{pass: 1'b1, pass_byte: texel.chan0[7:0], half: texel.chan0};
    lane_g = '{pass: 1'b1, pass_byte: texel.chan1[7:0], half: texel.chan1};
    lane_b = '{pass: 1'b1, pass_byte: texel.chan2[7:0], half: texel.chan2};
    lane_a = '{pass: 1'b1, pass_byte: texel.chan3[7:0], half: texel.chan3};
    case (format_mode)
      hfsrgb_pkg::MODE_HALF: begin
        lane_r.pass = 1'b0;
        lane_g.pass = 1'b0;
        lane_b.pass = 1'b0;
        lane_a.pass = 1'b0;
      end
      hfsrgb_pkg::MODE_BGRA8: begin
        lane_r.pass_byte = texel.chan2[7:0];
        lane_b.pass_byte = texel.chan0[7:0];
      end
      default: begin
      end
    endcase
  end

  // advance a stage when it is empty or the one ahead advances
  assign en[NSTG]    = take;
  assign texel_ready = en[0];

  for (genvar j = 0; j < NSTG; j++) begin : g_ctrl
    assign en[j] = !vld[j] || en[j+1];
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en[j]) begin
          vld[j] <= texel_valid;
        end
      end
      always_ff @(posedge clk) begin
        if (en[j]) begin
          last_pipe[j] <= texel.last_in;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en[j]) begin
          vld[j] <= vld[j-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en[j]) begin
          last_pipe[j] <= last_pipe[j-1];
        end
      end
    end
  end

  hfsrgb_colour_lane u_lane_r (
    .clk  (clk),
    .en   (en[NSTG-1:0]),
    .lane (lane_r),
    .code (mi.red),
    .clip (clip[0])
  );

  hfsrgb_colour_lane u_lane_g (
    .clk  (clk),
    .en   (en[NSTG-1:0]),
    .lane (lane_g),
    .code (mi.green),
    .clip (clip[1])
  );

  hfsrgb_colour_lane u_lane_b (
    .clk  (clk),
    .en   (en[NSTG-1:0]),
    .lane (lane_b),
    .code (mi.blue),
    .clip (clip[2])
  );

  hfsrgb_alpha_lane u_lane_a (
    .clk   (clk),
    .en    (en[NSTG-1:0]),
    .lane  (lane_a),
    .alpha (mi.alpha)
  );

  assign mi.clip = clip;
  assign mi.last = last_pipe[NSTG-1];

  hfsrgb_merge u_merge (
    .clk          (clk),
    .rst          (rst),
    .mi           (mi),
    .mi_valid     (vld[NSTG-1]),
    .take         (take),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

`default_nettype wire
